// ----- rtl/core/slc_pkg.sv -----
package slc_pkg;

    localparam logic [1:0] FN_LOOKUP  = 2'd0;
    localparam logic [1:0] FN_INSTALL = 2'd1;
    localparam logic [1:0] FN_PROBE   = 2'd2;
    localparam logic [1:0] FN_INVAL   = 2'd3;

    localparam logic CFG_ACTIVE_SHARDS = 1'b0;
    localparam logic CFG_WAYS_IN_USE   = 1'b1;

    localparam logic [3:0] ACTIVE_SHARDS_RST = 4'd8;
    localparam logic [4:0] WAYS_IN_USE_RST   = 5'd16;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] node_id;
    } t_slc_req;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [63:0] victim_id;
        logic [2:0]  shard_index;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } t_slc_resp;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_DECIDE,
        B_SWEEP,
        B_DONE
    } t_slc_bstate;

    typedef enum logic [1:0] {
        M_NONE,
        M_INV,
        M_HIT,
        M_INS
    } t_slc_mode;

endpackage

// ----- rtl/core/slc_front.sv -----
module slc_front #(
    parameter int SW     = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  slc_pkg::t_slc_req i_req,
    input  logic [SW:0]       i_nshards,
    output logic              o_job_vld,
    input  logic              i_job_rdy,
    output logic [1:0]        o_func,
    output logic [63:0]       o_id,
    output logic [SW-1:0]     o_shard
);

    logic          r_busy;
    logic          r_done;
    logic [2:0]    r_step;
    logic [1:0]    r_func;
    logic [63:0]   r_id;
    logic [63:0]   r_sh;
    logic [SW-1:0] r_rem;
    logic [SW-1:0] n_rem;

    // one byte of the id per cycle, MSB first, restoring remainder
    always_comb begin
        logic [SW:0] t;
        t = {1'b0, r_rem};
        for (int i = 0; i < 8; i++) begin
            t = {t[SW-1:0], r_sh[63-i]};
            if (t >= i_nshards) begin
                t = t - i_nshards;
            end
        end
        n_rem = t[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (!r_busy) begin
            if (i_valid) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_step <= '0;
            end
        end else if (!r_done) begin
            r_step <= r_step + 3'd1;
            if (r_step == 3'd7) begin
                r_done <= 1'b1;
            end
        end else if (i_job_rdy) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_valid) begin
            r_func <= i_req.func;
            r_id   <= i_req.node_id;
            r_sh   <= i_req.node_id;
            r_rem  <= '0;
        end else if (r_busy && !r_done) begin
            r_rem <= n_rem;
            r_sh  <= {r_sh[55:0], 8'd0};
        end
    end

    assign o_stall   = r_busy;
    assign o_job_vld = r_done;
    assign o_func    = r_func;
    assign o_id      = r_id;
    assign o_shard   = r_rem;

endmodule

// ----- rtl/core/slc_queue.sv -----
module slc_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_rdy,
    input  logic         i_pop,
    output logic         o_vld,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_data [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         push_en;
    logic         pop_en;

    assign o_rdy   = (r_cnt != 2'd2);
    assign o_vld   = (r_cnt != 2'd0);
    assign o_data  = r_data[r_rp];
    assign push_en = i_push && o_rdy;
    assign pop_en  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push_en) begin
                r_wp <= !r_wp;
            end
            if (pop_en) begin
                r_rp <= !r_rp;
            end
            if (push_en && !pop_en) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop_en && !push_en) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_data[r_wp] <= i_data;
        end
    end

endmodule

// ----- rtl/core/slc_back.sv -----
module slc_back #(
    parameter int SHARDS = 8,
    parameter int WAYS   = 16,
    parameter int SW     = 3,
    parameter int WCW    = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_vld,
    output logic               o_job_pop,
    input  logic [1:0]         i_func,
    input  logic [63:0]        i_id,
    input  logic [SW-1:0]      i_shard,
    input  logic [WCW-1:0]     i_nways,
    output logic               o_valid,
    input  logic               i_stall,
    output slc_pkg::t_slc_resp o_resp
);

    localparam int NENT = SHARDS * WAYS;
    localparam int AW   = (NENT > 1) ? $clog2(NENT) : 1;
    localparam int WIW  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RW   = WIW;

    logic [63:0]   m_tag  [NENT];
    logic [RW-1:0] m_rank [NENT];
    logic [NENT-1:0] r_valid;

    slc_pkg::t_slc_bstate r_state, n_state;
    slc_pkg::t_slc_mode   r_mode, n_mode;

    logic [1:0]     r_func;
    logic [63:0]    r_id;
    logic [SW-1:0]  r_shard;
    logic [WCW-1:0] r_way;
    logic           r_pv;
    logic [WIW-1:0] r_pway;
    logic [63:0]    r_tag_q;
    logic [RW-1:0]  r_rank_q;
    logic           r_v_q;

    logic [WCW-1:0] r_count;
    logic           r_found;
    logic [WIW-1:0] r_fway;
    logic [RW-1:0]  r_frank;
    logic           r_hold;
    logic [WIW-1:0] r_oway;
    logic [RW-1:0]  r_orank;
    logic [63:0]    r_otag;
    logic           r_hfree;
    logic [WIW-1:0] r_freew;
    logic [WIW-1:0] r_slot;

    logic           r_hit;
    logic           r_evicted;
    logic [63:0]    r_victim;
    logic [31:0]    r_hits;
    logic [31:0]    r_miss;

    logic           r_ovld;
    slc_pkg::t_slc_resp r_out;

    logic [AW-1:0]  a_base;
    logic [WIW-1:0] rd_way;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic           way_end;
    logic           evict;
    logic [WIW-1:0] slot;
    logic           has_slot;
    logic           inc_hit;
    logic           inc_miss;
    logic [RW-1:0]  new_rank;
    logic           out_free;

    assign a_base  = AW'(r_shard) * AW'(WAYS);
    assign way_end = (r_way == WCW'(WAYS));
    assign rd_way  = way_end ? '0 : r_way[WIW-1:0];
    assign rd_addr = a_base + AW'(rd_way);
    assign wr_addr = a_base + AW'(r_pway);
    assign out_free = !r_ovld || !i_stall;

    // outcome of the shard scan
    always_comb begin
        evict    = 1'b0;
        slot     = r_freew;
        has_slot = 1'b0;
        inc_hit  = 1'b0;
        inc_miss = 1'b0;
        n_mode   = slc_pkg::M_NONE;
        if (r_found) begin
            if (r_func == slc_pkg::FN_INVAL) begin
                n_mode = slc_pkg::M_INV;
            end else begin
                n_mode  = slc_pkg::M_HIT;
                inc_hit = (r_func == slc_pkg::FN_INSTALL) || (r_func == slc_pkg::FN_PROBE);
            end
        end else begin
            case (r_func)
                slc_pkg::FN_LOOKUP, slc_pkg::FN_INSTALL: begin
                    evict = (r_count >= i_nways) && r_hold;
                    if (evict) begin
                        slot = (r_hfree && (r_freew < r_oway)) ? r_freew : r_oway;
                    end
                    has_slot = evict || r_hfree;
                    n_mode   = has_slot ? slc_pkg::M_INS : slc_pkg::M_NONE;
                    inc_miss = (r_func == slc_pkg::FN_LOOKUP);
                    inc_hit  = (r_func == slc_pkg::FN_INSTALL);
                end
                slc_pkg::FN_PROBE: begin
                    inc_miss = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // rank after the update, for the entry returning from the read
    always_comb begin
        new_rank = r_rank_q;
        case (r_mode)
            slc_pkg::M_INV: begin
                if (r_v_q && (r_rank_q > r_frank)) begin
                    new_rank = r_rank_q - RW'(1);
                end
            end
            slc_pkg::M_HIT: begin
                if (r_pway == r_fway) begin
                    new_rank = '0;
                end else if (r_v_q && (r_rank_q < r_frank)) begin
                    new_rank = r_rank_q + RW'(1);
                end
            end
            slc_pkg::M_INS: begin
                if (r_pway == r_slot) begin
                    new_rank = '0;
                end else if (r_v_q) begin
                    new_rank = r_rank_q + RW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        o_job_pop = 1'b0;
        case (r_state)
            slc_pkg::B_IDLE: begin
                if (i_job_vld) begin
                    o_job_pop = 1'b1;
                    n_state   = slc_pkg::B_SCAN;
                end
            end
            slc_pkg::B_SCAN: begin
                if (way_end) begin
                    n_state = slc_pkg::B_DECIDE;
                end
            end
            slc_pkg::B_DECIDE: begin
                n_state = (n_mode == slc_pkg::M_NONE) ? slc_pkg::B_DONE : slc_pkg::B_SWEEP;
            end
            slc_pkg::B_SWEEP: begin
                if (way_end) begin
                    n_state = slc_pkg::B_DONE;
                end
            end
            slc_pkg::B_DONE: begin
                if (out_free) begin
                    n_state = slc_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = slc_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slc_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and status registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hits  <= '0;
            r_miss  <= '0;
            r_ovld  <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_pv <= ((r_state == slc_pkg::B_SCAN) || (r_state == slc_pkg::B_SWEEP)) && !way_end;
            if (r_state == slc_pkg::B_DECIDE) begin
                r_hits <= r_hits + {31'd0, inc_hit};
                r_miss <= r_miss + {31'd0, inc_miss};
                if (n_mode == slc_pkg::M_INV) begin
                    r_valid[a_base + AW'(r_fway)] <= 1'b0;
                end else if (n_mode == slc_pkg::M_INS) begin
                    if (evict) begin
                        r_valid[a_base + AW'(r_oway)] <= 1'b0;
                    end
                    r_valid[a_base + AW'(slot)] <= 1'b1;
                end
            end
            if (r_state == slc_pkg::B_DONE && out_free) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // storage ports
    always_ff @(posedge i_clk) begin
        r_tag_q  <= m_tag[rd_addr];
        r_rank_q <= m_rank[rd_addr];
        r_v_q    <= r_valid[rd_addr];
        r_pway   <= rd_way;
        if (r_state == slc_pkg::B_DECIDE && n_mode == slc_pkg::M_INS) begin
            m_tag[a_base + AW'(slot)] <= r_id;
        end
        if (r_state == slc_pkg::B_SWEEP && r_pv) begin
            m_rank[wr_addr] <= new_rank;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            slc_pkg::B_IDLE: begin
                r_func  <= i_func;
                r_id    <= i_id;
                r_shard <= i_shard;
                r_way   <= '0;
                r_count <= '0;
                r_found <= 1'b0;
                r_hold  <= 1'b0;
                r_hfree <= 1'b0;
            end
            slc_pkg::B_SCAN: begin
                if (!way_end) begin
                    r_way <= r_way + WCW'(1);
                end
                if (r_pv) begin
                    if (r_v_q) begin
                        r_count <= r_count + WCW'(1);
                        if (!r_found && (r_tag_q == r_id)) begin
                            r_found <= 1'b1;
                            r_fway  <= r_pway;
                            r_frank <= r_rank_q;
                        end
                        if (!r_hold || (r_rank_q > r_orank)) begin
                            r_hold  <= 1'b1;
                            r_oway  <= r_pway;
                            r_orank <= r_rank_q;
                            r_otag  <= r_tag_q;
                        end
                    end else if (!r_hfree) begin
                        r_hfree <= 1'b1;
                        r_freew <= r_pway;
                    end
                end
            end
            slc_pkg::B_DECIDE: begin
                r_mode    <= n_mode;
                r_slot    <= slot;
                r_way     <= '0;
                r_hit     <= r_found;
                r_evicted <= evict;
                r_victim  <= evict ? r_otag : 64'd0;
            end
            slc_pkg::B_SWEEP: begin
                if (!way_end) begin
                    r_way <= r_way + WCW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        logic [SW+2:0] sh_ext;
        sh_ext = {3'd0, r_shard};
        if (r_state == slc_pkg::B_DONE && out_free) begin
            r_out.hit         <= r_hit;
            r_out.evicted     <= r_evicted;
            r_out.victim_id   <= r_victim;
            r_out.shard_index <= sh_ext[2:0];
            r_out.hit_total   <= r_hits;
            r_out.miss_total  <= r_miss;
        end
    end

    assign o_valid = r_ovld;
    assign o_resp  = r_out;

endmodule

// ----- rtl/core/sharded_lru_tag_cache_top.sv -----
// Sharded LRU tag cache for 64-bit ids: each request picks shard (id mod active shards), then
// runs lookup-or-insert, install, probe or invalidate against that shard's tags and recency
// ranks and returns one response with hit, victim and running hit/miss totals. A request first
// passes the front for the byte-serial shard remainder, then in the back one pass reads the
// shard's tags through the single tag/rank memory port, a decide step follows, a second pass
// rewrites ranks (skipped when the decide step finds no invalidate, hit or insert to apply),
// and the response goes into the output register. The front computes the next request's
// shard while the back works, through a two-entry queue.
// No clearing pass is needed after reset. Configuration writes must happen while idle.
module sharded_lru_tag_cache_top #(
    parameter int SHARDS = 8,
    parameter int WAYS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  slc_pkg::t_slc_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output slc_pkg::t_slc_resp o_out_resp,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [4:0]         i_cfg_data
);

    localparam int SW  = (SHARDS > 1) ? $clog2(SHARDS) : 1;
    localparam int WCW = $clog2(WAYS + 1);

    logic [3:0]     r_active_shards;
    logic [4:0]     r_ways_in_use;
    logic [SW:0]    nshards;
    logic [WCW-1:0] nways;

    logic           f_vld;
    logic           q_rdy;
    logic [1:0]     f_func;
    logic [63:0]    f_id;
    logic [SW-1:0]  f_shard;
    logic           q_vld;
    logic           q_pop;
    logic [SW+65:0] q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_shards <= slc_pkg::ACTIVE_SHARDS_RST;
            r_ways_in_use   <= slc_pkg::WAYS_IN_USE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == slc_pkg::CFG_ACTIVE_SHARDS) begin
                r_active_shards <= i_cfg_data[3:0];
            end else begin
                r_ways_in_use <= i_cfg_data;
            end
        end
    end

    // clamp to 1..SHARDS and 1..WAYS
    always_comb begin
        logic [7:0] as8;
        logic [7:0] wu8;
        as8 = {4'd0, r_active_shards};
        wu8 = {3'd0, r_ways_in_use};
        if (as8 == 8'd0) begin
            nshards = (SW+1)'(1);
        end else if (as8 > 8'(SHARDS)) begin
            nshards = (SW+1)'(SHARDS);
        end else begin
            nshards = (SW+1)'(as8);
        end
        if (wu8 == 8'd0) begin
            nways = WCW'(1);
        end else if (wu8 > 8'(WAYS)) begin
            nways = WCW'(WAYS);
        end else begin
            nways = WCW'(wu8);
        end
    end

    slc_front #(
        .SW    (SW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_req    (i_in_req),
        .i_nshards(nshards),
        .o_job_vld(f_vld),
        .i_job_rdy(q_rdy),
        .o_func   (f_func),
        .o_id     (f_id),
        .o_shard  (f_shard)
    );

    slc_queue #(
        .W(SW + 66)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (f_vld),
        .i_data ({f_shard, f_func, f_id}),
        .o_rdy  (q_rdy),
        .i_pop  (q_pop),
        .o_vld  (q_vld),
        .o_data (q_data)
    );

    slc_back #(
        .SHARDS(SHARDS),
        .WAYS  (WAYS),
        .SW    (SW),
        .WCW   (WCW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job_vld(q_vld),
        .o_job_pop(q_pop),
        .i_func   (q_data[65:64]),
        .i_id     (q_data[63:0]),
        .i_shard  (q_data[SW+65:66]),
        .i_nways  (nways),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_resp   (o_out_resp)
    );

endmodule
